@@ rtl/core/bur_pkg.sv @@
// Shared types and constants for the buffered UART channel core.
`default_nettype none

package bur_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LINE  = 2'd2;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/bur_ring.sv @@
// Byte ring buffer: memory, wrap-tagged head/tail pointers, fill status.
`default_nettype none

module bur_ring #(
  parameter int DEPTH = bur_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [7:0]                   push_data,
  input  logic                         pop,
  output logic [7:0]                   pop_data,
  output bur_pkg::ring_stat_t          stat,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import bur_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(2 * DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail_next;
  logic [AW-1:0] head_slot;
  logic [AW-1:0] tail_slot;
  logic [PW:0]   diff;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(2 * DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= PW'(DEPTH)) ? p - PW'(DEPTH) : p;
    ptr_slot = s[AW-1:0];
  endfunction

  assign head_slot = ptr_slot(head);
  assign tail_slot = ptr_slot(tail);
  assign head_next = ptr_inc(head);
  assign tail_next = ptr_inc(tail);

  // pointers run modulo 2*DEPTH so full and empty stay distinct
  assign diff = {1'b0, tail} - {1'b0, head} + ((tail < head) ? (PW+1)'(2 * DEPTH) : '0);
  assign count = diff[CW-1:0];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (head == tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (push) tail <= tail_next;
      if (pop)  head <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[tail_slot] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (pop) pop_data <= mem[head_slot];
  end

endmodule

`default_nettype wire

@@ rtl/core/buffered_uart_channel_core.sv @@
// Top level of the buffered UART channel core.
// The core takes one item per cycle and returns exactly one result item for each, in the cycle
// after acceptance; the result sits in an output register, so a new item is taken whenever
// that register is empty or being drained in the same cycle. Each item touches at most one
// entry of each ring, read or written through a registered memory port, plus pointer
// compares. Counts, interrupt enables and fault on the result reflect the state after the
// item. An overrun on a line event latches fault, after which items are still consumed
// but change nothing until rst.
`default_nettype none

module buffered_uart_channel_core #(
  parameter int DEPTH = bur_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bur_pkg::ACT_W-1:0]   action,
  input  logic [7:0]                  host_byte,
  input  logic                        line_data_ready,
  input  logic                        line_tx_empty,
  input  logic                        line_overrun,
  input  logic [7:0]                  line_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        write_accepted,
  output logic                        read_valid,
  output logic [7:0]                  read_byte,
  output logic                        rx_taken,
  output logic                        send_valid,
  output logic [7:0]                  send_byte,
  output logic                        rx_irq_enable,
  output logic                        tx_irq_enable,
  output logic                        fault,
  output logic [$clog2(DEPTH+1)-1:0]  rx_count,
  output logic [$clog2(DEPTH+1)-1:0]  tx_count
);
  import bur_pkg::*;

  logic       accept;
  logic       live;
  logic       rx_push;
  logic       rx_pop;
  logic       tx_push;
  logic       tx_pop;
  logic       rx_clear;
  logic       tx_clear;
  logic       ovr;
  logic [7:0] rx_rd;
  logic [7:0] tx_rd;
  ring_stat_t rx_stat;
  ring_stat_t tx_stat;

  logic fault_mark;
  logic rx_en;
  logic tx_en;
  logic w_acc;
  logic r_val;
  logic taken;
  logic s_val;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign live     = accept & ~fault_mark;

  always_comb begin
    rx_push  = 1'b0;
    rx_pop   = 1'b0;
    tx_push  = 1'b0;
    tx_pop   = 1'b0;
    rx_clear = 1'b0;
    tx_clear = 1'b0;
    ovr      = 1'b0;
    unique case (action)
      ACT_WRITE: tx_push = live & ~tx_stat.full;
      ACT_READ:  rx_pop  = live & ~rx_stat.empty;
      ACT_LINE: begin
        ovr = live & line_overrun;
        if (live && !line_overrun) begin
          if (line_data_ready) begin
            rx_push  = ~rx_stat.full;
            rx_clear = rx_stat.full;
          end
          if (line_tx_empty) begin
            tx_pop   = ~tx_stat.empty;
            tx_clear = tx_stat.empty;
          end
        end
      end
      default: ;
    endcase
  end

  bur_ring #(.DEPTH(DEPTH)) u_rx_ring (
    .clk       (clk),
    .rst       (rst),
    .push      (rx_push),
    .push_data (line_byte),
    .pop       (rx_pop),
    .pop_data  (rx_rd),
    .stat      (rx_stat),
    .count     (rx_count)
  );

  bur_ring #(.DEPTH(DEPTH)) u_tx_ring (
    .clk       (clk),
    .rst       (rst),
    .push      (tx_push),
    .push_data (host_byte),
    .pop       (tx_pop),
    .pop_data  (tx_rd),
    .stat      (tx_stat),
    .count     (tx_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_mark <= 1'b0;
      rx_en      <= 1'b1;
      tx_en      <= 1'b0;
    end else begin
      if (ovr) fault_mark <= 1'b1;
      if (rx_pop)        rx_en <= 1'b1;
      else if (rx_clear) rx_en <= 1'b0;
      if (tx_push)       tx_en <= 1'b1;
      else if (tx_clear) tx_en <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      w_acc     <= 1'b0;
      r_val     <= 1'b0;
      taken     <= 1'b0;
      s_val     <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
      w_acc     <= tx_push;
      r_val     <= rx_pop;
      taken     <= rx_push;
      s_val     <= tx_pop;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // ring state only moves on accept, so status taken straight from it is the post-item view
  assign write_accepted = w_acc;
  assign read_valid     = r_val;
  assign read_byte      = r_val ? rx_rd : 8'd0;
  assign rx_taken       = taken;
  assign send_valid     = s_val;
  assign send_byte      = s_val ? tx_rd : 8'd0;
  assign rx_irq_enable  = rx_en;
  assign tx_irq_enable  = tx_en;
  assign fault          = fault_mark;

endmodule

`default_nettype wire

@@ rtl/core/bur_checker.sv @@
// Port-level checks for the buffered UART channel core, bound to the top level.
`default_nettype none

module bur_checker #(
  parameter int DEPTH = bur_pkg::DEPTH_DEFAULT
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        write_accepted,
  input logic                        read_valid,
  input logic [7:0]                  read_byte,
  input logic                        rx_taken,
  input logic                        send_valid,
  input logic                        fault,
  input logic [$clog2(DEPTH+1)-1:0]  rx_count,
  input logic [$clog2(DEPTH+1)-1:0]  tx_count
);

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault |=> fault)
    else $error("fault dropped without reset");

  a_frozen_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> !write_accepted && !read_valid && !rx_taken && !send_valid)
    else $error("activity reported while faulted");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (rx_count <= ($clog2(DEPTH+1))'(DEPTH)) && (tx_count <= ($clog2(DEPTH+1))'(DEPTH)))
    else $error("ring count above depth");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> read_byte == 8'd0)
    else $error("read byte nonzero without a read");

  a_stalled_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_byte) && $stable(send_valid))
    else $error("stalled result changed");

endmodule

bind buffered_uart_channel_core bur_checker #(.DEPTH(DEPTH)) u_bur_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .write_accepted (write_accepted),
  .read_valid     (read_valid),
  .read_byte      (read_byte),
  .rx_taken       (rx_taken),
  .send_valid     (send_valid),
  .fault          (fault),
  .rx_count       (rx_count),
  .tx_count       (tx_count)
);

`default_nettype wire
